@@ sv/morse_keying_sequencer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Morse keying sequencer
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYING_SEQUENCER_TOP_ASSERT_SVH
`define MORSE_KEYING_SEQUENCER_TOP_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define MKS_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("mks: invariant violated");

// When the condition holds, the consequence must hold in the same cycle.
`define MKS_ASSERT_IMPLIES(name, cond, conseq) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("mks: implication violated");

`endif

@@ sv/mks_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse keying sequencer package
// Payload types, the queued descriptor and the Morse element tables.
// ----------------------------------------------------------------------------
package mks_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [6:0] CHAR_SPACE   = 7'h20;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
   localparam logic [6:0] CHAR_DIGIT_9 = 7'h39;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
   localparam logic [6:0] CASE_OFFSET  = 7'h20;

   localparam logic [2:0] DOT_UNITS        = 3'd1;
   localparam logic [2:0] DASH_UNITS       = 3'd3;
   localparam logic [2:0] ELEM_GAP_UNITS   = 3'd1;
   localparam logic [2:0] LETTER_GAP_UNITS = 3'd2;
   localparam logic [2:0] WORD_GAP_UNITS   = 3'd6;
   localparam logic [2:0] NO_UNITS         = 3'd0;

   typedef struct packed {
      logic [6:0] character;
      logic       next_is_space;
   } req_payload_type;

   typedef struct packed {
      logic       level;
      logic [2:0] units;
      logic       last;
      logic       invalid;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      KIND_CODE,
      KIND_SPACE,
      KIND_INVALID
   } desc_kind_type;

   // Elements are stored first element in bit 0; a set bit is a dash.
   typedef struct packed {
      logic [2:0] len;
      logic [4:0] pattern;
   } morse_code_type;

   typedef struct packed {
      desc_kind_type  kind;
      morse_code_type code;
      logic           next_is_space;
   } desc_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MARK,
      SEQ_GAP,
      SEQ_LETTER_GAP,
      SEQ_WORD_GAP,
      SEQ_INVALID
   } seq_state_type;

   function automatic morse_code_type letter_code(input logic [4:0] idx);
      morse_code_type c;
      unique case (idx)
         5'd0:    c = '{3'd2, 5'b00010};
         5'd1:    c = '{3'd4, 5'b00001};
         5'd2:    c = '{3'd4, 5'b00101};
         5'd3:    c = '{3'd3, 5'b00001};
         5'd4:    c = '{3'd1, 5'b00000};
         5'd5:    c = '{3'd4, 5'b00100};
         5'd6:    c = '{3'd3, 5'b00011};
         5'd7:    c = '{3'd4, 5'b00000};
         5'd8:    c = '{3'd2, 5'b00000};
         5'd9:    c = '{3'd4, 5'b01110};
         5'd10:   c = '{3'd3, 5'b00101};
         5'd11:   c = '{3'd4, 5'b00010};
         5'd12:   c = '{3'd2, 5'b00011};
         5'd13:   c = '{3'd2, 5'b00001};
         5'd14:   c = '{3'd3, 5'b00111};
         5'd15:   c = '{3'd4, 5'b00110};
         5'd16:   c = '{3'd4, 5'b01011};
         5'd17:   c = '{3'd3, 5'b00010};
         5'd18:   c = '{3'd3, 5'b00000};
         5'd19:   c = '{3'd1, 5'b00001};
         5'd20:   c = '{3'd3, 5'b00100};
         5'd21:   c = '{3'd4, 5'b01000};
         5'd22:   c = '{3'd3, 5'b00110};
         5'd23:   c = '{3'd4, 5'b01001};
         5'd24:   c = '{3'd4, 5'b01101};
         5'd25:   c = '{3'd4, 5'b00011};
         default: c = '{3'd1, 5'b00000};
      endcase
      return c;
   endfunction

   function automatic morse_code_type digit_code(input logic [3:0] idx);
      morse_code_type c;
      unique case (idx)
         4'd0:    c = '{3'd5, 5'b11111};
         4'd1:    c = '{3'd5, 5'b11110};
         4'd2:    c = '{3'd5, 5'b11100};
         4'd3:    c = '{3'd5, 5'b11000};
         4'd4:    c = '{3'd5, 5'b10000};
         4'd5:    c = '{3'd5, 5'b00000};
         4'd6:    c = '{3'd5, 5'b00001};
         4'd7:    c = '{3'd5, 5'b00011};
         4'd8:    c = '{3'd5, 5'b00111};
         4'd9:    c = '{3'd5, 5'b01111};
         default: c = '{3'd5, 5'b00000};
      endcase
      return c;
   endfunction

endpackage

@@ sv/mks_chan_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mks_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/mks_front.sv @@
// ----------------------------------------------------------------------------
// Morse keying front end
// Accepts characters, folds case, classifies them and looks up the elements.
// ----------------------------------------------------------------------------
module mks_front (
   mks_chan_if.sink           req,
   input  logic               q_full,
   output logic               q_push,
   output mks_pkg::desc_type  q_desc
);
   import mks_pkg::*;

   logic [6:0] folded;
   logic [6:0] letter_off;
   logic [6:0] digit_off;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      if (req.payload.character >= CHAR_LOWER_A && req.payload.character <= CHAR_LOWER_Z) begin
         folded = req.payload.character - CASE_OFFSET;
      end else begin
         folded = req.payload.character;
      end
   end

   assign letter_off = folded - CHAR_UPPER_A;
   assign digit_off  = folded - CHAR_DIGIT_0;

   always_comb begin
      q_desc.next_is_space = req.payload.next_is_space;
      q_desc.code          = '{3'd1, 5'b00000};
      priority if (folded == CHAR_SPACE) begin
         q_desc.kind = KIND_SPACE;
      end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
         q_desc.kind = KIND_CODE;
         q_desc.code = letter_code(letter_off[4:0]);
      end else if (folded >= CHAR_DIGIT_0 && folded <= CHAR_DIGIT_9) begin
         q_desc.kind = KIND_CODE;
         q_desc.code = digit_code(digit_off[3:0]);
      end else begin
         q_desc.kind = KIND_INVALID;
      end
   end

endmodule

@@ sv/mks_queue.sv @@
// ----------------------------------------------------------------------------
// Morse keying descriptor queue
// Small register FIFO between the front end and the segment sequencer.
// ----------------------------------------------------------------------------
module mks_queue #(
   parameter int unsigned DEPTH = mks_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mks_pkg::desc_type  push_desc,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output mks_pkg::desc_type  head
);
   import mks_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ sv/mks_back.sv @@
// ----------------------------------------------------------------------------
// Morse keying segment sequencer
// Walks one descriptor element by element and issues one segment per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module mks_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  mks_pkg::desc_type  q_head,
   output logic               q_pop,
   mks_chan_if.source         rsp
);
   import mks_pkg::*;

   seq_state_type   state_ff, state_in;
   logic [4:0]      pattern_ff, pattern_in;
   logic [2:0]      remain_ff, remain_in;
   logic            nsp_ff, nsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type seg;
   seq_state_type   start_state;
   logic            advance;
   logic            seg_last;

   // The output register is free when empty or being drained this cycle.
   assign advance = !rsp_valid_ff || rsp.ready;

   always_comb begin
      unique case (q_head.kind)
         KIND_CODE:    start_state = SEQ_MARK;
         KIND_SPACE:   start_state = SEQ_WORD_GAP;
         KIND_INVALID: start_state = SEQ_INVALID;
         default:      start_state = SEQ_INVALID;
      endcase
   end

   // Segment for the current state.
   always_comb begin
      seg = '{1'b0, NO_UNITS, 1'b1, 1'b0};
      unique case (state_ff)
         SEQ_IDLE:       seg = '{1'b0, NO_UNITS, 1'b0, 1'b0};
         SEQ_MARK:       seg = '{1'b1, pattern_ff[0] ? DASH_UNITS : DOT_UNITS, 1'b0, 1'b0};
         SEQ_GAP:        seg = '{1'b0, ELEM_GAP_UNITS, (remain_ff == 3'd1) && nsp_ff, 1'b0};
         SEQ_LETTER_GAP: seg = '{1'b0, LETTER_GAP_UNITS, 1'b1, 1'b0};
         SEQ_WORD_GAP:   seg = '{1'b0, WORD_GAP_UNITS, 1'b1, 1'b0};
         SEQ_INVALID:    seg = '{1'b0, NO_UNITS, 1'b1, 1'b1};
         default:        seg = '{1'b0, NO_UNITS, 1'b1, 1'b1};
      endcase
      seg_last = seg.last;
   end

   // Next state; the next descriptor is taken while the last segment goes out.
   always_comb begin
      state_in   = state_ff;
      pattern_in = pattern_ff;
      remain_in  = remain_ff;
      nsp_in     = nsp_ff;
      q_pop      = 1'b0;
      if (advance) begin
         if (state_ff == SEQ_IDLE || seg_last) begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               state_in   = start_state;
               pattern_in = q_head.code.pattern;
               remain_in  = q_head.code.len;
               nsp_in     = q_head.next_is_space;
            end else begin
               state_in = SEQ_IDLE;
            end
         end else begin
            unique case (state_ff)
               SEQ_MARK: state_in = SEQ_GAP;
               SEQ_GAP: begin
                  if (remain_ff != 3'd1) begin
                     state_in   = SEQ_MARK;
                     pattern_in = {1'b0, pattern_ff[4:1]};
                     remain_in  = remain_ff - 3'd1;
                  end else begin
                     state_in = SEQ_LETTER_GAP;
                  end
               end
               default: state_in = SEQ_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = (state_ff != SEQ_IDLE);
         rsp_data_in  = seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff  <= pattern_in;
      remain_ff   <= remain_in;
      nsp_ff      <= nsp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

@@ sv/morse_keying_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Morse keying sequencer top level
// Turns ASCII characters into timed on/off keying segments.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one word per character: the ASCII code and a flag that
//   the next character is a space. rsp_ch returns the keying segments of
//   that character in order: level, length in 200 ms units, a last flag on
//   the final segment and an invalid flag for unsupported characters.
//   A character gives 2*N+1 segments for N Morse elements (2*N when the next
//   character is a space), one segment for a space or an invalid code; at
//   most 11. The sequencer issues one segment per cycle while the receiver
//   takes them; that segment rate sets the sustained throughput.
//   An accepted character is written to the queue, then taken into the
//   sequencer state, then its first segment enters the output register;
//   the next character's first segment follows the last one with no gap.
//   A descriptor queue lets characters be accepted while segments drain.
//   When the receiver stalls, the output register holds its word and the
//   queue fills; req_ch.ready drops once the queue is full.
//   Synchronous reset empties the queue and drops any segment in flight.
// ----------------------------------------------------------------------------
module morse_keying_sequencer_top #(
   parameter int unsigned QUEUE_DEPTH = mks_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mks_chan_if.sink    req_ch,
   mks_chan_if.source  rsp_ch
);
   import mks_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   desc_type q_desc;
   desc_type q_head;

   mks_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_desc (q_desc)
   );

   mks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   mks_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

`include "morse_keying_sequencer_top_assert.svh"

   `MKS_ASSERT_ALWAYS(a_no_pop_when_empty, !(q_pop && q_empty))
   `MKS_ASSERT_IMPLIES(a_invalid_is_single,
      rsp_ch.valid && rsp_ch.payload.invalid,
      rsp_ch.payload.last && !rsp_ch.payload.level && rsp_ch.payload.units == NO_UNITS)
   `MKS_ASSERT_IMPLIES(a_mark_is_element,
      rsp_ch.valid && rsp_ch.payload.level,
      !rsp_ch.payload.last && (rsp_ch.payload.units == DOT_UNITS ||
                               rsp_ch.payload.units == DASH_UNITS))

endmodule
